[rtl/core/peos_pkg.sv]
package peos_pkg;

  localparam int DATA_W     = 32;
  localparam int Q_FRAC     = 16;
  localparam int Q_ONE      = 65536;
  localparam int DMG_W      = 17;
  localparam int MAG_W      = 48;           // magnitude of an intermediate, up to 2^47
  localparam int HALF_W     = MAG_W / 2;
  localparam int PROD_W     = 2 * MAG_W;
  localparam int TERM_W     = MAG_W + 1;    // two's complement form of a term
  localparam int ACC_W      = TERM_W + 2;   // sum of four terms
  localparam int NSTG       = 19;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [MAG_W-1:0] LIM_MAG = MAG_W'(1) << (MAG_W - 1);
  localparam logic [MAG_W-1:0] ONE_MAG = MAG_W'(Q_ONE);
  localparam logic [DMG_W-1:0] ONE_DMG = DMG_W'(Q_ONE);

  localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic [REG_IDX_W-1:0] REG_INV_RHO0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEF0    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEF1    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COEF2    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COEF3    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_INV_DT   = 3'd5;

  typedef struct packed {
    logic [DATA_W-1:0]        density;
    logic signed [DATA_W-1:0] prev_pressure;
    logic [DMG_W-1:0]         damage_level;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pressure;
    logic signed [DATA_W-1:0] pressure_rate;
    logic                     saturated;
  } out_item_t;

  // sign-magnitude operand of the fixed-point multiplier
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } sm_t;

  function automatic logic signed [TERM_W-1:0] sm_to_s(sm_t v);
    logic signed [TERM_W-1:0] pos;
    pos = $signed({1'b0, v.mag});
    return v.neg ? -pos : pos;
  endfunction

  function automatic sm_t s32_to_sm(logic [DATA_W-1:0] v);
    sm_t                r;
    logic [DATA_W-1:0]  m;
    m     = v[DATA_W-1] ? (~v + 1'b1) : v;
    r.neg = v[DATA_W-1];
    r.mag = {{(MAG_W-DATA_W){1'b0}}, m};
    return r;
  endfunction

endpackage

[rtl/core/peos_in_if.sv]
interface peos_in_if;
  import peos_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/peos_out_if.sv]
interface peos_out_if;
  import peos_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/polynomial_eos_pressure.sv]
// Throughput: one transaction per cycle; every stage is a register, and the
//   19-stage pipeline (multiplier stages, two parallel polynomial lanes, rate
//   multiply) advances as a whole when the output register is free or taken.
// Reset (rst_n low, synchronous): all stage valid bits clear, inv_rho0 and
//   inv_dt return to 1.0, coefficients to 0. Payload registers are not reset.
module polynomial_eos_pressure (
  input  logic                           clk,
  input  logic                           rst_n,
  peos_in_if.sink                        in_chan,
  peos_out_if.source                     out_chan,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [peos_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [peos_pkg::DATA_W-1:0]    pwdata,
  output logic [peos_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);
  import peos_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers. Coefficients 1-3 are also kept in
  // sign-magnitude form at write time so the multipliers see them directly.
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0]        inv_rho0_r, inv_dt_r;
  logic signed [DATA_W-1:0] coef0_r, coef1_r, coef2_r, coef3_r;
  sm_t                      c1_sm_r, c2_sm_r, c3_sm_r;
  logic [REG_IDX_W-1:0]     reg_idx;
  logic                     cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_rho0_r <= DATA_W'(Q_ONE);
      inv_dt_r   <= DATA_W'(Q_ONE);
      coef0_r    <= '0;
      coef1_r    <= '0;
      coef2_r    <= '0;
      coef3_r    <= '0;
      c1_sm_r    <= '0;
      c2_sm_r    <= '0;
      c3_sm_r    <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_INV_RHO0: inv_rho0_r <= pwdata;
        REG_COEF0:    coef0_r    <= pwdata;
        REG_COEF1: begin
          coef1_r <= pwdata;
          c1_sm_r <= s32_to_sm(pwdata);
        end
        REG_COEF2: begin
          coef2_r <= pwdata;
          c2_sm_r <= s32_to_sm(pwdata);
        end
        REG_COEF3: begin
          coef3_r <= pwdata;
          c3_sm_r <= s32_to_sm(pwdata);
        end
        REG_INV_DT:   inv_dt_r   <= pwdata;
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_INV_RHO0: prdata = inv_rho0_r;
      REG_COEF0:    prdata = coef0_r;
      REG_COEF1:    prdata = coef1_r;
      REG_COEF2:    prdata = coef2_r;
      REG_COEF3:    prdata = coef3_r;
      REG_INV_DT:   prdata = inv_dt_r;
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: the whole pipe moves together; it holds only while the
  // output register is full and not taken.
  // ---------------------------------------------------------------------------
  logic              adv;
  logic [NSTG:1]     vld_r;
  logic [NSTG:1]     clip_r, clip_nxt;   // running saturation flag per stage
  logic [13:1]       has_dmg_r;
  logic signed [DATA_W-1:0] prev_r [1:15];

  assign adv           = ~vld_r[NSTG] | out_chan.ready;
  assign in_chan.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-1:1], in_chan.valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: density * inv_rho0, damage factor (1 - damage) with damage
  // saturated at 1.0.
  // ---------------------------------------------------------------------------
  logic [2*DATA_W-1:0] prod1_r;
  logic [DMG_W-1:0]    dmg_sat;
  logic [DMG_W-1:0]    fac1_r, fac2_r;

  assign dmg_sat = (in_chan.data.damage_level > ONE_DMG) ? ONE_DMG
                                                         : in_chan.data.damage_level;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod1_r   <= in_chan.data.density * inv_rho0_r;
      fac1_r    <= ONE_DMG - dmg_sat;
      has_dmg_r <= {has_dmg_r[12:1], (in_chan.data.damage_level != '0)};
      prev_r[1] <= in_chan.data.prev_pressure;
      for (int k = 2; k <= 15; k++) begin
        prev_r[k] <= prev_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: mu = ratio - 1.0, only the upper clamp can trigger.
  // ---------------------------------------------------------------------------
  logic [MAG_W-1:0] ratio, mu_dif;
  logic             mu_over;
  sm_t              mu_nxt, mu_r, mu3_r, mu4_r;

  always_comb begin
    ratio   = prod1_r[2*DATA_W-1:Q_FRAC];
    mu_dif  = ratio - ONE_MAG;
    mu_over = 1'b0;
    if (ratio >= ONE_MAG) begin
      mu_over    = mu_dif > LIM_MAG;
      mu_nxt.neg = 1'b0;
      mu_nxt.mag = mu_over ? LIM_MAG : mu_dif;
    end else begin
      mu_nxt.neg = 1'b1;
      mu_nxt.mag = ONE_MAG - ratio;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mu_r   <= mu_nxt;
      fac2_r <= fac1_r;
      mu3_r  <= mu_r;
      mu4_r  <= mu3_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 3-4: damaged compression m_d = mu * (1 - damage).
  // ---------------------------------------------------------------------------
  sm_t  fac_sm, md_q;
  logic md_clip;

  assign fac_sm.neg = 1'b0;
  assign fac_sm.mag = {{(MAG_W-DMG_W){1'b0}}, fac2_r};

  peos_qmul u_md (
    .clk  (clk),
    .en   (adv),
    .a    (mu_r),
    .b    (fac_sm),
    .q    (md_q),
    .clip (md_clip)
  );

  // ---------------------------------------------------------------------------
  // Stages 5-13: two polynomial lanes, lane 0 on mu, lane 1 on m_d.
  //   5-6  m^2, c1*m      7-8  m^3, c2*m^2      9-10 c3*m^3
  //   11   terms to two's complement (c2 term only under compression)
  //   12   pair sums      13   lane pressure
  // ---------------------------------------------------------------------------
  sm_t                     lane_m    [2];
  logic signed [ACC_W-1:0] lane_p_r  [2];
  logic                    lane_clip [2];

  assign lane_m[0] = mu4_r;
  assign lane_m[1] = md_q;

  for (genvar g = 0; g < 2; g++) begin : g_lane
    sm_t                      m2_q, t1_q, m3_q, t2_q, t3_q;
    logic                     m2_c, t1_c, m3_c, t2_c, t3_c;
    sm_t                      m_d_r  [5:6];
    sm_t                      t1_d_r [7:10];
    sm_t                      t2_d_r [9:10];
    logic [10:5]              pos_r;
    logic [13:7]              lc_r;
    logic                     pos4;
    logic signed [TERM_W-1:0] t1s_r, t2s_r, t3s_r;
    logic signed [ACC_W-1:0]  sa_r, sb_r;

    assign pos4 = (lane_m[g].mag != '0) && !lane_m[g].neg;

    peos_qmul u_m2 (.clk(clk), .en(adv), .a(lane_m[g]), .b(lane_m[g]), .q(m2_q), .clip(m2_c));
    peos_qmul u_t1 (.clk(clk), .en(adv), .a(c1_sm_r),   .b(lane_m[g]), .q(t1_q), .clip(t1_c));
    peos_qmul u_m3 (.clk(clk), .en(adv), .a(m2_q),      .b(m_d_r[6]),  .q(m3_q), .clip(m3_c));
    peos_qmul u_t2 (.clk(clk), .en(adv), .a(c2_sm_r),   .b(m2_q),      .q(t2_q), .clip(t2_c));
    peos_qmul u_t3 (.clk(clk), .en(adv), .a(c3_sm_r),   .b(m3_q),      .q(t3_q), .clip(t3_c));

    always_ff @(posedge clk) begin
      if (adv) begin
        m_d_r[5]  <= lane_m[g];
        m_d_r[6]  <= m_d_r[5];
        pos_r     <= {pos_r[9:5], pos4};
        t1_d_r[7] <= t1_q;
        for (int k = 8; k <= 10; k++) begin
          t1_d_r[k] <= t1_d_r[k-1];
        end
        t2_d_r[9]  <= t2_q;
        t2_d_r[10] <= t2_d_r[9];
        // quadratic term clip counts only when the term is used
        lc_r[7]  <= m2_c | t1_c;
        lc_r[8]  <= lc_r[7];
        lc_r[9]  <= lc_r[8] | m3_c | (t2_c & pos_r[8]);
        lc_r[10] <= lc_r[9];
        lc_r[11] <= lc_r[10] | t3_c;
        lc_r[12] <= lc_r[11];
        lc_r[13] <= lc_r[12];
        t1s_r    <= sm_to_s(t1_d_r[10]);
        t2s_r    <= pos_r[10] ? sm_to_s(t2_d_r[10]) : '0;
        t3s_r    <= sm_to_s(t3_q);
        sa_r     <= ACC_W'(coef0_r) + ACC_W'(t1s_r);
        sb_r     <= ACC_W'(t2s_r) + ACC_W'(t3s_r);
        lane_p_r[g] <= sa_r + sb_r;
      end
    end

    assign lane_clip[g] = lc_r[13];
  end

  // ---------------------------------------------------------------------------
  // Stage 14: keep the larger pressure when damage is present.
  // Stage 15: clamp to 32 bits.
  // Stage 16: p - prev as sign and magnitude (both differences in parallel).
  // Stages 17-18: rate multiply by inv_dt.
  // Stage 19: clamp rate, output register.
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0]  p14_r;
  logic signed [DATA_W-1:0] p15_r, p16_r, p17_r, p18_r;
  logic                     p_over;
  logic signed [DATA_W-1:0] p_clamp;
  logic [DATA_W:0]          d_pos, d_neg;
  sm_t                      diff_r, dt_sm, rate_q;
  logic                     rate_qclip;
  logic                     rate_over;
  logic signed [DATA_W-1:0] rate_val;
  logic signed [DATA_W-1:0] out_p_r, out_rate_r;

  always_comb begin
    p_over  = 1'b1;
    if (p14_r > ACC_W'(S32_MAX)) begin
      p_clamp = S32_MAX;
    end else if (p14_r < ACC_W'(S32_MIN)) begin
      p_clamp = S32_MIN;
    end else begin
      p_clamp = p14_r[DATA_W-1:0];
      p_over  = 1'b0;
    end
  end

  assign d_pos = {p15_r[DATA_W-1], p15_r} - {prev_r[15][DATA_W-1], prev_r[15]};
  assign d_neg = {prev_r[15][DATA_W-1], prev_r[15]} - {p15_r[DATA_W-1], p15_r};

  assign dt_sm.neg = 1'b0;
  assign dt_sm.mag = {{(MAG_W-DATA_W){1'b0}}, inv_dt_r};

  peos_qmul u_rate (
    .clk  (clk),
    .en   (adv),
    .a    (diff_r),
    .b    (dt_sm),
    .q    (rate_q),
    .clip (rate_qclip)
  );

  always_comb begin
    if (rate_q.neg) begin
      rate_over = rate_q.mag > (MAG_W'(1) << (DATA_W - 1));
      rate_val  = rate_over ? S32_MIN : -$signed(rate_q.mag[DATA_W-1:0]);
    end else begin
      rate_over = rate_q.mag > MAG_W'(S32_MAX);
      rate_val  = rate_over ? S32_MAX : $signed(rate_q.mag[DATA_W-1:0]);
    end
  end

  // saturation flag follows the transaction, picking up clips where they occur
  always_comb begin
    clip_nxt[1] = 1'b0;
    for (int k = 2; k <= NSTG; k++) begin
      clip_nxt[k] = clip_r[k-1];
    end
    clip_nxt[2]  = clip_r[1] | mu_over;
    clip_nxt[5]  = clip_r[4] | (md_clip & has_dmg_r[4]);
    clip_nxt[14] = clip_r[13] | lane_clip[0] | (lane_clip[1] & has_dmg_r[13]);
    clip_nxt[15] = clip_r[14] | p_over;
    clip_nxt[19] = clip_r[18] | rate_qclip | rate_over;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      clip_r     <= clip_nxt;
      p14_r      <= (has_dmg_r[13] && (lane_p_r[1] > lane_p_r[0])) ? lane_p_r[1]
                                                                   : lane_p_r[0];
      p15_r      <= p_clamp;
      diff_r.neg <= d_pos[DATA_W];
      diff_r.mag <= {{(MAG_W-DATA_W-1){1'b0}}, (d_pos[DATA_W] ? d_neg : d_pos)};
      p16_r      <= p15_r;
      p17_r      <= p16_r;
      p18_r      <= p17_r;
      out_p_r    <= p18_r;
      out_rate_r <= rate_val;
    end
  end

  assign out_chan.valid              = vld_r[NSTG];
  assign out_chan.data.pressure      = out_p_r;
  assign out_chan.data.pressure_rate = out_rate_r;
  assign out_chan.data.saturated     = clip_r[NSTG];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline valid bits moved during a stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> vld_r[1])
    else $error("accepted transaction did not enter stage 1");

  a_mu_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] |-> (mu_r.mag <= LIM_MAG))
    else $error("compression exceeds intermediate range");

  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vld_r[NSTG-1] |=> out_chan.valid)
    else $error("transaction lost before the output register");

endmodule

[rtl/core/peos_qmul.sv]
// Q16.16 sign-magnitude multiply, truncate toward zero, clamp to 2^47.
// Two stages: 24x24 partial products, then sum, shift and clamp.
module peos_qmul (
  input  logic          clk,
  input  logic          en,
  input  peos_pkg::sm_t a,
  input  peos_pkg::sm_t b,
  output peos_pkg::sm_t q,
  output logic          clip
);
  import peos_pkg::*;

  logic [2*HALF_W-1:0]     pp_ll_r, pp_lh_r, pp_hl_r, pp_hh_r;
  logic                    neg_r;
  logic [PROD_W-1:0]       full;
  logic [PROD_W-Q_FRAC-1:0] shifted;
  logic                    over;
  sm_t                     q_r;
  logic                    clip_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll_r <= a.mag[HALF_W-1:0]     * b.mag[HALF_W-1:0];
      pp_lh_r <= a.mag[HALF_W-1:0]     * b.mag[MAG_W-1:HALF_W];
      pp_hl_r <= a.mag[MAG_W-1:HALF_W] * b.mag[HALF_W-1:0];
      pp_hh_r <= a.mag[MAG_W-1:HALF_W] * b.mag[MAG_W-1:HALF_W];
      neg_r   <= a.neg ^ b.neg;
    end
  end

  always_comb begin
    full    = PROD_W'(pp_ll_r)
            + (PROD_W'(pp_lh_r) << HALF_W)
            + (PROD_W'(pp_hl_r) << HALF_W)
            + (PROD_W'(pp_hh_r) << MAG_W);
    shifted = full[PROD_W-1:Q_FRAC];
    over    = shifted > (PROD_W-Q_FRAC)'(LIM_MAG);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r.neg <= neg_r;
      q_r.mag <= over ? LIM_MAG : shifted[MAG_W-1:0];
      clip_r  <= over;
    end
  end

  assign q    = q_r;
  assign clip = clip_r;

endmodule

[test/polynomial_eos_pressure_tb.sv]
module polynomial_eos_pressure_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import peos_pkg::*;

  // Intermediate clamp (+-2^47 raw) and the 32-bit output range, as 64-bit values
  localparam longint MID_LIM = longint'(LIM_MAG);
  localparam longint WORD_HI = longint'(S32_MAX);
  localparam longint WORD_LO = longint'(S32_MIN);

  // Register indexes past the end of the map; writes there must be dropped
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // Pipeline is 19 deep; settle window after the last result
  localparam int SETTLE_CYCLES = 40;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [DATA_W-1:0]     pwdata;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;

  peos_in_if  in_chan();
  peos_out_if out_chan();

  polynomial_eos_pressure u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the register file, updated when a write completes
  logic [DATA_W-1:0] regs_model [0:5];

  // Expected results, oldest first, pushed when a particle transaction is accepted
  out_item_t pending_results[$];

  int error_count       = 0;
  bit no_idle           = 1'b0;  // both sides stream without gaps
  int sink_hold_cycles  = 0;     // receiver back-pressure request, counted down below
  bit any_clip;                  // set by the predictor whenever a value is clipped

  // ---------------------------------------------------------------------------
  // Pressure predictor
  // ---------------------------------------------------------------------------

  function automatic longint sat_wide(longint v);
    if (v > MID_LIM) begin
      any_clip = 1'b1;
      return MID_LIM;
    end
    if (v < -MID_LIM) begin
      any_clip = 1'b1;
      return -MID_LIM;
    end
    return v;
  endfunction

  function automatic longint sat_word(longint v);
    if (v > WORD_HI) begin
      any_clip = 1'b1;
      return WORD_HI;
    end
    if (v < WORD_LO) begin
      any_clip = 1'b1;
      return WORD_LO;
    end
    return v;
  endfunction

  // Q16.16 multiply: exact product in 128 bits, truncate toward zero, clamp to 2^47
  function automatic longint fixmul(longint a, longint b);
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [127:0] q;
    ma = (a < 0) ? 64'(-a) : 64'(a);
    mb = (b < 0) ? 64'(-b) : 64'(b);
    q  = (128'(ma) * 128'(mb)) >> Q_FRAC;
    if (q > 128'(MID_LIM)) begin
      any_clip = 1'b1;
      q = 128'(MID_LIM);
    end
    return ((a < 0) != (b < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint coef_of(logic [REG_IDX_W-1:0] idx);
    return longint'($signed(regs_model[idx]));
  endfunction

  // Cubic in the compression; the quadratic term only counts under compression
  function automatic longint cubic_pressure(longint m);
    longint m2;
    longint m3;
    longint acc;
    m2  = fixmul(m, m);
    m3  = fixmul(m2, m);
    acc = coef_of(REG_COEF0) + fixmul(coef_of(REG_COEF1), m) +
          fixmul(coef_of(REG_COEF3), m3);
    if (m > 0)
      acc += fixmul(coef_of(REG_COEF2), m2);
    return acc;
  endfunction

  function automatic out_item_t eos_result(in_item_t it);
    logic [63:0]      ratio;
    logic [DMG_W-1:0] dmg;
    longint           mu;
    longint           p;
    longint           pd;
    longint           p_out;
    longint           rate;
    out_item_t        r;
    any_clip = 1'b0;
    ratio = (64'(it.density) * 64'(regs_model[REG_INV_RHO0])) >> Q_FRAC;
    mu    = sat_wide(longint'(ratio) - longint'(Q_ONE));
    p     = cubic_pressure(mu);
    dmg   = it.damage_level;
    // damaged material: second evaluation at scaled compression, keep the larger
    if (dmg != '0) begin
      if (dmg > ONE_DMG)
        dmg = ONE_DMG;
      pd = cubic_pressure(fixmul(mu, longint'(Q_ONE) - longint'(dmg)));
      if (pd > p)
        p = pd;
    end
    p_out = sat_word(p);
    rate  = sat_word(fixmul(p_out - longint'($signed(it.prev_pressure)),
                            longint'(regs_model[REG_INV_DT])));
    r.pressure      = p_out[DATA_W-1:0];
    r.pressure_rate = rate[DATA_W-1:0];
    r.saturated     = any_clip;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic in_item_t mk_particle(logic [DATA_W-1:0] dens,
                                           logic [DATA_W-1:0] prev,
                                           logic [DMG_W-1:0]  dmg);
    in_item_t it;
    it.density       = dens;
    it.prev_pressure = prev;
    it.damage_level  = dmg;
    return it;
  endfunction

  function automatic in_item_t rand_particle();
    in_item_t it;
    case ($urandom_range(0, 9))
      0:       it.density = '0;
      1:       it.density = '1;
      2, 3:    it.density = $urandom;
      default: it.density = $urandom_range(32'h0000_8000, 32'h0003_0000);  // 0.5 .. 3.0
    endcase
    if ($urandom_range(0, 9) < 3)
      it.prev_pressure = $urandom;
    else
      it.prev_pressure = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;  // +-32.0
    case ($urandom_range(0, 9))
      0, 1, 2, 3: it.damage_level = '0;
      4:          it.damage_level = ONE_DMG;
      5:          it.damage_level = $urandom_range(Q_ONE + 1, 2 ** DMG_W - 1);
      default:    it.damage_level = $urandom_range(1, Q_ONE - 1);
    endcase
    return it;
  endfunction

  function automatic logic [DATA_W-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0:       return S32_MAX;
      1:       return S32_MIN;
      2:       return $urandom;
      3:       return '0;
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;  // +-16.0
    endcase
  endfunction

  // reciprocal registers (inv_rho0, inv_dt)
  function automatic logic [DATA_W-1:0] rand_recip();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return $urandom_range(32'h0000_4000, 32'h0004_0000);  // 0.25 .. 4.0
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Bus tasks
  // ---------------------------------------------------------------------------

  // Offer one particle; on acceptance record its expected result.
  // valid stays high when no gap follows so back-to-back transactions stream.
  task automatic send_particle(input in_item_t it);
    in_chan.valid <= 1'b1;
    in_chan.data  <= it;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    pending_results.push_back(eos_result(it));
    if (!no_idle && $urandom_range(0, 99) < 33) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic wait_results_drained();
    if (in_chan.valid) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // APB write: setup, access, then idle
  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx <= REG_INV_DT)
      regs_model[idx] = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read_check(input logic [REG_IDX_W-1:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== regs_model[idx]) begin
      $display("%0t register %0d readback mismatch: expected %h, actual %h",
               $time, idx, regs_model[idx], prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_registers();
    for (int r = REG_INV_RHO0; r <= REG_INV_DT; r++)
      cfg_read_check(REG_IDX_W'(r));
  endtask

  // Full reprogram; only ever done with the pipeline empty
  task automatic load_config(input logic [DATA_W-1:0] rho, input logic [DATA_W-1:0] c0,
                             input logic [DATA_W-1:0] c1, input logic [DATA_W-1:0] c2,
                             input logic [DATA_W-1:0] c3, input logic [DATA_W-1:0] dt);
    wait_results_drained();
    cfg_write(REG_INV_RHO0, rho);
    cfg_write(REG_COEF0, c0);
    cfg_write(REG_COEF1, c1);
    cfg_write(REG_COEF2, c2);
    cfg_write(REG_COEF3, c3);
    cfg_write(REG_INV_DT, dt);
    check_registers();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: zero coefficients, so pressure is 0 and rate is -prev_pressure.
  // The most negative prev_pressure makes the rate clip.
  task automatic test_reset_state();
    check_registers();
    send_particle(mk_particle('0, S32_MAX, '0));
    send_particle(mk_particle(32'h0001_0000, S32_MIN, '0));
    send_particle(mk_particle('1, 32'h0001_0000, ONE_DMG));
    wait_results_drained();
  endtask

  // Every register written and read back; writes past the map leave all alone
  task automatic test_register_access();
    load_config(32'h0001_8000, 32'h0000_4000, 32'hFFFF_0000, 32'h0002_0000,
                32'h0000_8000, 32'h0002_0000);
    cfg_write(REG_SPARE_LO, $urandom);
    cfg_write(REG_SPARE_HI, $urandom);
    check_registers();
    send_particle(mk_particle(32'h0001_4000, 32'h0000_1000, '0));
    send_particle(mk_particle(32'h0000_C000, 32'hFFFF_F000, 17'h0_4000));
    wait_results_drained();
  endtask

  task automatic test_directed_cases();
    // 1.0 density reference, p = 1 + 2mu + 3mu^2 - 0.5mu^3, rate scale 10.0
    load_config(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                32'hFFFF_8000, 32'h000A_0000);
    send_particle(mk_particle('0, '0, '0));                      // tension, no quadratic
    send_particle(mk_particle(32'h0001_0000, '0, '0));           // mu exactly zero
    send_particle(mk_particle(32'h0001_8000, 32'h0001_0000, '0)); // compression
    send_particle(mk_particle(32'h0001_8000, '0, 17'h0_8000));   // half damage
    send_particle(mk_particle(32'h0000_8000, '0, 17'h0_8000));   // damaged tension
    send_particle(mk_particle(32'h0001_8000, '0, ONE_DMG));      // full damage, damaged lane at coef0
    send_particle(mk_particle(32'h0001_8000, '0, '1));           // damage above one
    send_particle(mk_particle(32'h0001_0001, '0, 17'h0_0001));   // smallest steps
    send_particle(mk_particle('1, '0, '0));                      // m^2 clips
    send_particle(mk_particle(32'h0001_0000, S32_MAX, '0));
    send_particle(mk_particle(32'h0001_0000, S32_MIN, '0));      // rate clips

    // Everything at its top or bottom end
    load_config('1, S32_MAX, S32_MIN, S32_MAX, S32_MIN, '1);
    send_particle(mk_particle('1, '0, '0));                      // mu clips at 2^47
    send_particle(mk_particle('1, 32'h1234_5678, ONE_DMG));
    send_particle(mk_particle(32'h0000_8000, '0, 17'h0_4000));
    send_particle(mk_particle('0, S32_MIN, '0));

    // Zero reciprocals: mu pinned at -1, rate always zero
    load_config('0, S32_MIN, '0, '0, '0, '0);
    send_particle(mk_particle('1, S32_MAX, '1));
    send_particle(mk_particle(32'h0001_0000, '0, '0));
    wait_results_drained();
  endtask

  // Receiver holds off long enough for the pipeline to fill and stall the
  // input; then the sender pauses for a full drain before resuming.
  task automatic test_output_backpressure();
    load_config(32'h0001_0000, 32'h0000_8000, 32'h0004_0000, 32'h0001_0000,
                32'h0000_2000, 32'h0001_0000);
    sink_hold_cycles = 300;
    repeat (60) send_particle(rand_particle());
    wait_results_drained();
    repeat (30) send_particle(rand_particle());
    wait_results_drained();
  endtask

  // Ten phases of random particles, each under its own register setting.
  // Phase 3 runs without any idling on either side.
  task automatic test_random_particles();
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        1:       load_config('1, S32_MAX, S32_MAX, S32_MAX, S32_MAX, '1);
        2:       load_config('0, S32_MIN, S32_MIN, S32_MIN, S32_MIN, '0);
        default: load_config(rand_recip(), rand_coef(), rand_coef(), rand_coef(),
                             rand_coef(), rand_recip());
      endcase
      no_idle = (ph == 3);
      repeat (65) send_particle(rand_particle());
    end
    wait_results_drained();
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready, forced low while a hold-off is requested
  // ---------------------------------------------------------------------------
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_cycles > 0) begin
        out_chan.ready <= 1'b0;
        sink_hold_cycles--;
      end else begin
        out_chan.ready <= no_idle || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each accepted transaction against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n === 1'b1 && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h %h %b", $time,
                 out_chan.data.pressure, out_chan.data.pressure_rate,
                 out_chan.data.saturated);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_chan.data.pressure !== want.pressure) begin
          $display("%0t pressure mismatch: expected %h, actual %h", $time,
                   want.pressure, out_chan.data.pressure);
          error_count++;
        end
        if (out_chan.data.pressure_rate !== want.pressure_rate) begin
          $display("%0t pressure_rate mismatch: expected %h, actual %h", $time,
                   want.pressure_rate, out_chan.data.pressure_rate);
          error_count++;
        end
        if (out_chan.data.saturated !== want.saturated) begin
          $display("%0t saturated mismatch: expected %b, actual %b", $time,
                   want.saturated, out_chan.data.saturated);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_chan.valid <= 1'b0;
    in_chan.data  <= '0;
    regs_model[REG_INV_RHO0] = DATA_W'(Q_ONE);
    regs_model[REG_COEF0]    = '0;
    regs_model[REG_COEF1]    = '0;
    regs_model[REG_COEF2]    = '0;
    regs_model[REG_COEF3]    = '0;
    regs_model[REG_INV_DT]   = DATA_W'(Q_ONE);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_register_access();
    test_directed_cases();
    test_output_backpressure();
    test_random_particles();

    // leftover expectations are caught by the timeout
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
